/* rtl/core/assert_macros.svh */
// Assertion helpers for the I2C master engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define I2CM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CM_ASSERT(lbl, clk, rst, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/i2cm_pkg.sv */
package i2cm_pkg;

   localparam int BYTE_BITS = 8;
   localparam int TICK_W    = 16;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STOP  = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } i2cm_op_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } i2cm_phase_type;

   typedef struct packed {
      i2cm_op_type          cmd;
      logic                 busy;
      i2cm_phase_type       phase;
      logic [3:0]           bit_cnt;
      logic [TICK_W-1:0]    tick;
      logic [BYTE_BITS-1:0] shift;
      logic                 ack;
      logic                 scl;
      logic                 sda;
      logic                 oe;
      logic                 nack;
      logic [BYTE_BITS-1:0] rx;
   } i2cm_state_type;

   localparam i2cm_state_type STATE_RESET = '{
      cmd:     OP_START,
      busy:    1'b0,
      phase:   PH_FIRST,
      bit_cnt: '0,
      tick:    '0,
      shift:   '0,
      ack:     1'b0,
      scl:     1'b1,
      sda:     1'b1,
      oe:      1'b1,
      nack:    1'b0,
      rx:      '0
   };

endpackage

/* rtl/core/i2c_master_byte_engine_top.sv */
// I2C master bus engine.
// req channel: one transfer per bus tick. tuser carries cmd_valid; tdata carries
//   the optional command (opcode, tx_byte, send_nack) and the sampled SDA level.
//   A command is taken only while the engine is idle; otherwise it is ignored.
// rsp channel: exactly one transfer per req transfer, giving the pin levels,
//   SDA drive enable, busy, a one-tick done pulse, rx_byte and nack_seen.
// csr: csr_we writes phase_ticks (ticks per bus phase); 0 acts as 1. The user must write
//   it only while idle; the block does not enforce it. A tick's response is registered and
//   valid in the cycle after its req transfer. Throughput: one tick per cycle unless rsp
//   stalls; the bus state and the response register advance together from one step of logic.
// A stalled rsp holds its data; req_tready drops only while a response is
//   waiting and rsp_tready is low, so no tick is lost.
// Reset: SCL and SDA high with SDA driven, engine idle, phase_ticks = 1,
//   rx_byte and nack_seen cleared, no response pending.
`include "assert_macros.svh"

module i2c_master_byte_engine_top
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[1:0], tx_byte[9:2], send_nack[10], sda_sample[11]
   input  logic        req_tuser,   // cmd_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // scl, sda, sda_oe, busy, done, rx_byte[12:5], nack[13]
);

   logic [TICK_W-1:0] phase_ticks_ff;
   i2cm_state_type    st_ff, st_in;
   logic              done_in;
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;
   logic              req_xfer;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   i2cm_step u_step (
      .cur         (st_ff),
      .cmd_valid   (req_tuser),
      .opcode      (i2cm_op_type'(req_tdata[1:0])),
      .tx_byte     (req_tdata[9:2]),
      .send_nack   (req_tdata[10]),
      .sda_sample  (req_tdata[11]),
      .phase_ticks (phase_ticks_ff),
      .nxt         (st_in),
      .done        (done_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= TICK_W'(1);
      end else if (csr_we) begin
         phase_ticks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            st_ff        <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= {2'b00, st_in.nack, st_in.rx, done_in, st_in.busy,
                         st_in.oe, st_in.sda, st_in.scl};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `I2CM_ASSERT(a_cmd_starts, clock, reset, req_xfer && req_tuser && !st_ff.busy |=> st_ff.busy, "idle command did not start")
   `I2CM_ASSERT(a_done_from_busy, clock, reset, req_xfer && done_in |-> st_ff.busy && !st_in.busy, "done without a running command")
   `I2CM_ASSERT(a_idle_clean, clock, reset, !st_ff.busy |-> st_ff.tick == '0 && st_ff.phase == PH_FIRST && st_ff.bit_cnt == '0, "idle engine holds stale counters")
   `I2CM_ASSERT_ALWAYS(a_bit_range, clock, reset || st_ff.bit_cnt <= 4'(BYTE_BITS), "bit counter out of range")

endmodule

/* rtl/core/i2cm_step.sv */
module i2cm_step
   import i2cm_pkg::*;
(
   input  i2cm_state_type     cur,
   input  logic               cmd_valid,
   input  i2cm_op_type        opcode,
   input  logic [7:0]         tx_byte,
   input  logic               send_nack,
   input  logic               sda_sample,
   input  logic [TICK_W-1:0]  phase_ticks,
   output i2cm_state_type     nxt,
   output logic               done
);

   // pin setup for the low phase of the bit at bit_cnt
   function automatic i2cm_state_type setup_bit(input i2cm_state_type s);
      i2cm_state_type r;
      r = s;
      r.scl = 1'b0;
      if (s.bit_cnt < 4'(BYTE_BITS)) begin
         if (s.cmd == OP_WRITE) begin
            r.oe  = 1'b1;
            r.sda = s.shift[BYTE_BITS-1];
         end else begin
            r.oe = 1'b0;
         end
      end else if (s.cmd == OP_WRITE) begin
         r.oe = 1'b0;
      end else begin
         r.oe  = 1'b1;
         r.sda = s.ack;
      end
      return r;
   endfunction

   i2cm_state_type adv;
   logic           adv_end;

   always_comb begin
      adv     = cur;
      adv_end = 1'b0;
      unique case (cur.cmd)
         OP_START: begin
            if (cur.phase == PH_FIRST) begin
               adv.scl   = 1'b1;
               adv.phase = PH_SECOND;
            end else if (cur.phase == PH_SECOND) begin
               adv.sda   = 1'b0;
               adv.phase = PH_THIRD;
            end else begin
               adv.scl = 1'b0;
               adv_end = 1'b1;
            end
         end
         OP_STOP: begin
            if (cur.phase == PH_FIRST) begin
               adv.scl   = 1'b1;
               adv.phase = PH_SECOND;
            end else begin
               adv.sda = 1'b1;
               adv_end = 1'b1;
            end
         end
         OP_WRITE, OP_READ: begin
            if (cur.phase == PH_FIRST) begin
               adv.scl   = 1'b1;
               adv.phase = PH_SECOND;
            end else if (cur.bit_cnt >= 4'(BYTE_BITS)) begin
               adv.scl = 1'b0;
               adv.oe  = 1'b1;
               adv_end = 1'b1;
               if (cur.cmd == OP_WRITE) begin
                  adv.nack = sda_sample;
               end else begin
                  adv.rx = cur.shift;
               end
            end else begin
               if (cur.cmd == OP_WRITE) begin
                  adv.shift = {cur.shift[BYTE_BITS-2:0], 1'b0};
               end else begin
                  adv.shift = {cur.shift[BYTE_BITS-2:0], sda_sample};
               end
               adv.bit_cnt = 4'(cur.bit_cnt + 4'd1);
               adv.phase   = PH_FIRST;
               adv         = setup_bit(adv);
            end
         end
         default: adv = cur;
      endcase
   end

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (!cur.busy) begin
         if (cmd_valid) begin
            nxt.cmd     = opcode;
            nxt.busy    = 1'b1;
            nxt.phase   = PH_FIRST;
            nxt.bit_cnt = '0;
            nxt.tick    = TICK_W'(1);
            if (opcode == OP_START) begin
               nxt.oe  = 1'b1;
               nxt.sda = 1'b1;
            end else if (opcode == OP_STOP) begin
               nxt.oe  = 1'b1;
               nxt.sda = 1'b0;
            end else begin
               nxt.shift = (opcode == OP_WRITE) ? tx_byte : '0;
               nxt.ack   = send_nack;
               nxt       = setup_bit(nxt);
            end
         end
      end else if (cur.tick >= phase_ticks) begin
         nxt      = adv;
         nxt.tick = TICK_W'(1);
         if (adv_end) begin
            nxt.busy    = 1'b0;
            nxt.phase   = PH_FIRST;
            nxt.bit_cnt = '0;
            nxt.tick    = '0;
            done        = 1'b1;
         end
      end else begin
         nxt.tick = TICK_W'(cur.tick + TICK_W'(1));
      end
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import i2cm_pkg::*;

   typedef struct packed {
      logic [1:0] pad;
      logic       nack;
      logic [7:0] rx;
      logic       done;
      logic       busy;
      logic       oe;
      logic       sda;
      logic       scl;
   } bus_pins_type;

   typedef struct {
      i2cm_op_type    op;
      bit             busy;
      i2cm_phase_type step;
      bit [3:0]       nbits;
      bit [15:0]      ticks;
      bit [15:0]      period;
      bit [7:0]       shifter;
      bit             ack_bit;
      bit             scl;
      bit             sda;
      bit             oe;
      bit             nack;
      bit [7:0]       rx;
   } engine_type;

   typedef struct {
      bit        go;
      bit [15:0] data;
   } bus_tick_type;

   typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   bus_tick_type tick_queue[$];
   bus_pins_type expected_pins[$];
   engine_type   model;
   engine_type   plan;
   bus_pins_type got;
   bus_pins_type want;
   int           send_gap_pct = 0;
   int           rsp_stall_pct = 0;
   int           mismatches = 0;
   int           planned = 0;

   i2c_master_byte_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic engine_type reset_engine();
      engine_type e;
      e.op = OP_START;
      e.busy = 1'b0;
      e.step = PH_FIRST;
      e.nbits = '0;
      e.ticks = '0;
      e.period = 16'd1;
      e.shifter = '0;
      e.ack_bit = 1'b0;
      e.scl = 1'b1;
      e.sda = 1'b1;
      e.oe = 1'b1;
      e.nack = 1'b0;
      e.rx = '0;
      return e;
   endfunction

   // pins for the SCL-low half of the bit at nbits (data bits, then acknowledge)
   function automatic void load_bit(inout engine_type e);
      e.scl = 1'b0;
      if (e.nbits < BYTE_BITS) begin
         if (e.op == OP_WRITE) begin
            e.oe = 1'b1;
            e.sda = e.shifter[7];
         end else begin
            e.oe = 1'b0;
         end
      end else if (e.op == OP_WRITE) begin
         e.oe = 1'b0;
      end else begin
         e.oe = 1'b1;
         e.sda = e.ack_bit;
      end
   endfunction

   function automatic bus_pins_type engine_tick(inout engine_type e, input bit go,
                                                input i2cm_op_type op, input bit [7:0] tx,
                                                input bit nak, input bit sda_in);
      bus_pins_type p;
      bit fin;
      p = '0;
      fin = 1'b0;
      if (!e.busy) begin
         if (go) begin
            e.op = op;
            e.busy = 1'b1;
            e.step = PH_FIRST;
            e.nbits = '0;
            e.ticks = 16'd1;
            case (op)
               OP_START: begin
                  e.oe = 1'b1;
                  e.sda = 1'b1;
               end
               OP_STOP: begin
                  e.oe = 1'b1;
                  e.sda = 1'b0;
               end
               default: begin
                  e.shifter = (op == OP_WRITE) ? tx : 8'h00;
                  e.ack_bit = nak;
                  load_bit(e);
               end
            endcase
         end
      end else if (e.ticks >= e.period) begin
         e.ticks = 16'd1;
         case (e.op)
            OP_START: begin
               if (e.step == PH_FIRST) begin
                  e.scl = 1'b1;
                  e.step = PH_SECOND;
               end else if (e.step == PH_SECOND) begin
                  e.sda = 1'b0;
                  e.step = PH_THIRD;
               end else begin
                  e.scl = 1'b0;
                  fin = 1'b1;
               end
            end
            OP_STOP: begin
               if (e.step == PH_FIRST) begin
                  e.scl = 1'b1;
                  e.step = PH_SECOND;
               end else begin
                  e.sda = 1'b1;
                  fin = 1'b1;
               end
            end
            default: begin
               if (e.step == PH_FIRST) begin
                  e.scl = 1'b1;
                  e.step = PH_SECOND;
               end else begin
                  // end of SCL high: sample and go low
                  e.scl = 1'b0;
                  if (e.nbits >= BYTE_BITS) begin
                     if (e.op == OP_WRITE) e.nack = sda_in;
                     else e.rx = e.shifter;
                     e.oe = 1'b1;
                     fin = 1'b1;
                  end else begin
                     if (e.op == OP_WRITE) e.shifter = {e.shifter[6:0], 1'b0};
                     else e.shifter = {e.shifter[6:0], sda_in};
                     e.nbits = e.nbits + 4'd1;
                     e.step = PH_FIRST;
                     load_bit(e);
                  end
               end
            end
         endcase
         if (fin) begin
            e.busy = 1'b0;
            e.step = PH_FIRST;
            e.nbits = '0;
            e.ticks = '0;
         end
      end else begin
         e.ticks = e.ticks + 16'd1;
      end
      p.scl = e.scl;
      p.sda = e.sda;
      p.oe = e.oe;
      p.busy = e.busy;
      p.done = fin;
      p.rx = e.rx;
      p.nack = e.nack;
      return p;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_tvalid <= 1'b1;
            req_tuser <= tick_queue[0].go;
            req_tdata <= tick_queue[0].data;
            void'(tick_queue.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = bus_pins_type'(rsp_tdata);
            if (expected_pins.size() == 0) begin
               if (mismatches < 10)
                  $display("mismatch: response %h with no transfer pending", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_pins.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("mismatch: expected scl=%0b sda=%0b oe=%0b busy=%0b done=%0b",
                              want.scl, want.sda, want.oe, want.busy, want.done,
                              " rx=%h nack=%0b pad=%b", want.rx, want.nack, want.pad);
                     $display("          got scl=%0b sda=%0b oe=%0b busy=%0b done=%0b",
                              got.scl, got.sda, got.oe, got.busy, got.done,
                              " rx=%h nack=%0b pad=%b", got.rx, got.nack, got.pad);
                  end
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_pins.push_back(engine_tick(model, req_tuser,
                                                i2cm_op_type'(req_tdata[1:0]),
                                                req_tdata[9:2], req_tdata[10],
                                                req_tdata[11]));
      end
   end

   task automatic push_tick(bit go, i2cm_op_type op, bit [7:0] tx, bit nak, bit sda);
      bus_tick_type t;
      t.go = go;
      t.data = {4'b0000, sda, nak, tx, op};
      tick_queue.push_back(t);
      void'(engine_tick(plan, go, op, tx, nak, sda));
      planned++;
   endtask

   // one command, the ticks it runs for, then a short idle gap
   task automatic issue(i2cm_op_type op, bit [7:0] tx, bit nak, sda_mode_type mode);
      bit sda;
      sda = (mode == SDA_RAND) ? 1'($urandom_range(1)) : (mode == SDA_HIGH);
      push_tick(1'b1, op, tx, nak, sda);
      while (plan.busy) begin
         sda = (mode == SDA_RAND) ? 1'($urandom_range(1)) : (mode == SDA_HIGH);
         // occasional command offered while busy, must be dropped
         push_tick($urandom_range(9) == 0, i2cm_op_type'($urandom_range(3)),
                   8'($urandom_range(255)), 1'($urandom_range(1)), sda);
      end
      repeat ($urandom_range(2))
         push_tick(1'b0, i2cm_op_type'($urandom_range(3)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic random_traffic(int count);
      int goal;
      goal = planned + count;
      while (planned < goal) begin
         if ($urandom_range(9) == 0) begin
            issue(i2cm_op_type'($urandom_range(3)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), SDA_RAND);
         end else begin
            issue(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
            repeat ($urandom_range(1, 3))
               issue($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                     1'($urandom_range(1)), SDA_RAND);
            issue(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
         end
      end
   endtask

   task automatic settle();
      while (tick_queue.size() != 0 || req_tvalid || expected_pins.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_phase(bit [15:0] ticks_per_phase, int gap_pct, int stall_pct);
      settle();
      @(posedge clock);
      csr_wdata <= ticks_per_phase;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      model.period = ticks_per_phase;
      plan.period = ticks_per_phase;
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   initial begin
      model = reset_engine();
      plan = reset_engine();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(OP_START, 8'h00, 1'b0, SDA_RAND);
      issue(OP_WRITE, 8'hff, 1'b0, SDA_LOW);
      issue(OP_WRITE, 8'h00, 1'b1, SDA_HIGH);
      issue(OP_WRITE, 8'ha5, 1'b1, SDA_RAND);
      issue(OP_READ, 8'h00, 1'b0, SDA_HIGH);
      issue(OP_READ, 8'hff, 1'b1, SDA_LOW);
      issue(OP_READ, 8'h5a, 1'b0, SDA_RAND);
      issue(OP_STOP, 8'h00, 1'b0, SDA_RAND);
      issue(OP_STOP, 8'hff, 1'b1, SDA_RAND);
      issue(OP_READ, 8'h3c, 1'b1, SDA_RAND);
      issue(OP_WRITE, 8'h81, 1'b0, SDA_RAND);

      // zero behaves as one tick per phase
      set_phase(16'd0, 0, 0);
      random_traffic(200);
      set_phase(16'd1, 64, 0);
      random_traffic(200);
      set_phase(16'($urandom_range(2, 5)), 0, 64);
      random_traffic(200);
      set_phase(16'd3, 31, 31);
      random_traffic(150);
      set_phase(16'd9, 0, 0);
      issue(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), SDA_RAND);
      set_phase(16'($urandom_range(1, 4)), 31, 31);
      random_traffic(100);
      settle();

      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("tb: errors");
      $finish;
   end

endmodule
